// ----- src/rshe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rshe_pkg;

  // Internal datapath widths: CORDIC x/y, and the wide Legendre/result lane
  localparam int XW = 34;
  localparam int MW = 44;

  localparam int ONE_Q30 = 1073741824;
  localparam logic signed [XW-1:0] ONE_X = XW'(ONE_Q30);
  localparam logic signed [XW-1:0] MINUS_ONE_X = -XW'(ONE_Q30);

  // Input word
  typedef struct packed {
    logic [2:0]        band;
    logic signed [3:0] order;
    logic [15:0]       polar_angle;
    logic [15:0]       azimuth_angle;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] harmonic_value;
    logic               bad_order;
  } out_word_t;

  // Classified job handed from the front end to the back end
  typedef struct packed {
    logic        bad;
    logic [2:0]  band;
    logic [2:0]  abs_order;
    logic        order_neg;
    logic        order_zero;
    logic [31:0] theta_turn;
    logic [31:0] phi_turn;
  } job_t;

  // CORDIC request and response
  typedef struct packed {
    logic        start;
    logic [31:0] turn;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [XW-1:0] cos_val;
    logic signed [XW-1:0] sin_val;
  } cordic_rsp_t;

endpackage

`default_nettype wire

// ----- src/real_spherical_harmonic_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Real spherical harmonic evaluator. Each input word carries band l, signed
// order m and two angles (theta as a fraction of pi, phi as a fraction of 2pi);
// each output word carries Y(l,m) in signed Q3.28 and a bad_order flag that is
// set, with a zero value, when |m| > l or l > MAX_BAND. A front end classifies
// words into a two-entry job queue; the back end evaluates one job at a time
// on a single iterative 24-step CORDIC and one shared 22 by 32 bit
// multiplier. Each recurrence step, run when l > |m|, is one multiply, one
// numerator step and a radix-16 divide; when m is not zero, a second CORDIC
// pass and two scaling multiplies follow. The output register lets the next
// job start while a result waits.

module real_spherical_harmonic_eval import rshe_pkg::*; #(
  parameter int MAX_BAND   = 7,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_word_t in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_word_t     out_word_o
);

  logic front_valid, front_ready;
  job_t front_word;
  logic job_valid, job_ready;
  job_t job_word;

  rshe_front #(
    .MAX_BAND   (MAX_BAND),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_word_o  (front_word)
  );

  rshe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_word_i  (front_word),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_ready),
    .pop_word_o   (job_word)
  );

  rshe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_word_i  (job_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ----- src/rshe_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rshe_cordic import rshe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cordic_req_t req_i,
  output cordic_rsp_t      rsp_o
);

  localparam int Steps = 24;
  localparam int StepW = $clog2(Steps);
  localparam logic signed [XW-1:0] Gain = XW'(652032874);

  // atan(2^-i) in turns, 2^32 per turn
  localparam logic [29:0] AtanTurn [Steps] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  logic signed [XW-1:0] x_q, y_q;
  logic signed [32:0]   z_q;
  logic [1:0]           quad_q;
  logic [StepW-1:0]     step_q;
  logic                 busy_q, done_q;

  logic signed [XW-1:0] dx, dy;
  logic signed [32:0]   da;

  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign da = $signed({3'b000, AtanTurn[step_q]});

  // Control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == StepW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  // Rotation datapath, one micro-rotation per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quad_q <= req_i.turn[31:30];
      z_q    <= $signed({3'b000, req_i.turn[29:0]});
      x_q    <= Gain;
      y_q    <= '0;
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - da;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + da;
      end
    end
  end

  // Quadrant fold
  always_comb begin
    rsp_o.done = done_q;
    unique case (quad_q)
      2'd0: begin
        rsp_o.cos_val = x_q;
        rsp_o.sin_val = y_q;
      end
      2'd1: begin
        rsp_o.cos_val = -y_q;
        rsp_o.sin_val = x_q;
      end
      2'd2: begin
        rsp_o.cos_val = -x_q;
        rsp_o.sin_val = -y_q;
      end
      default: begin
        rsp_o.cos_val = y_q;
        rsp_o.sin_val = -x_q;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/rshe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rshe_front import rshe_pkg::*; #(
  parameter int MAX_BAND   = 7,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_word_t in_word_i,
  output logic          job_valid_o,
  input  wire logic     job_ready_i,
  output job_t          job_word_o
);

  localparam logic [15:0] AngleMask =
    (ANGLE_BITS >= 16) ? 16'hFFFF : 16'((1 << ANGLE_BITS) - 1);

  job_t        job_d, job_q;
  logic        job_valid_q;
  logic [3:0]  abs_order;
  logic [15:0] pa, aa;

  // Classify the incoming word
  always_comb begin
    abs_order = in_word_i.order[3] ? 4'(-in_word_i.order) : 4'(in_word_i.order);
    pa = in_word_i.polar_angle & AngleMask;
    aa = in_word_i.azimuth_angle & AngleMask;
    job_d.bad        = (abs_order > {1'b0, in_word_i.band}) ||
                       (int'(in_word_i.band) > MAX_BAND);
    job_d.band       = in_word_i.band;
    job_d.abs_order  = abs_order[2:0];
    job_d.order_neg  = in_word_i.order[3];
    job_d.order_zero = (in_word_i.order == 4'sd0);
    job_d.theta_turn = 32'(32'(pa) << (31 - ANGLE_BITS));
    job_d.phi_turn   = 32'((32'(aa) << (32 - ANGLE_BITS)) * 32'(abs_order[2:0]));
  end

  assign in_ready_o  = !job_valid_q || job_ready_i;
  assign job_valid_o = job_valid_q;
  assign job_word_o  = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      job_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/rshe_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rshe_fifo import rshe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire job_t push_word_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output job_t      pop_word_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_word_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_word_i;
  end

endmodule

`default_nettype wire

// ----- src/rshe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rshe_back import rshe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  input  wire job_t job_word_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_word_t out_word_o
);

  localparam int DivSteps = MW / 4;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam int HalfW    = MW / 2;
  localparam int PartW    = HalfW + 32;
  localparam int ProdW    = MW + 32;
  localparam logic signed [31:0] Sqrt2 = 32'sd1518500250;
  localparam logic [63:0] Inv4Pi = 64'd91746578227440000;

  // Folded norm K(l,m)*(2m-1)!! in Q.30, worked out at elaboration
  function automatic logic [63:0][31:0] norm_rom();
    logic [63:0][31:0] rom;
    logic [63:0]  d, fn, fd, num, rem, rr, res, bit_v;
    logic [127:0] dividend, quo, prod;
    rom = '0;
    for (int l = 0; l < 8; l++) begin
      for (int am = 0; am <= l; am++) begin
        d = 64'd1;
        for (int k = 1; k <= am; k++) d = d * 64'(2 * k - 1);
        fn = 64'd1;
        for (int k = 2; k <= l - am; k++) fn = fn * 64'(k);
        fd = 64'd1;
        for (int k = 2; k <= l + am; k++) fd = fd * 64'(k);
        num = 64'(2 * l + 1) * d * d * fn;
        // num * 2^60 / fd by restoring long division
        dividend = 128'(num) << 60;
        rem = '0;
        quo = '0;
        for (int b = 127; b >= 0; b--) begin
          rem = {rem[62:0], dividend[b]};
          quo = {quo[126:0], 1'b0};
          if (rem >= fd) begin
            rem = rem - fd;
            quo[0] = 1'b1;
          end
        end
        prod = 128'(quo[63:0]) * 128'(Inv4Pi);
        rr = prod[123:60];
        // floor square root
        res = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
          if (rr >= res + bit_v) begin
            rr = rr - res - bit_v;
            res = (res >> 1) + bit_v;
          end else begin
            res = res >> 1;
          end
          bit_v = bit_v >> 2;
        end
        rom[l * 8 + am] = res[31:0];
      end
    end
    return rom;
  endfunction

  localparam logic [63:0][31:0] NormRom = norm_rom();

  function automatic logic signed [31:0] clamp_unit(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] c;
    c = v;
    if (v > ONE_X) c = ONE_X;
    if (v < MINUS_ONE_X) c = MINUS_ONE_X;
    return 32'(c);
  endfunction

  typedef enum logic [3:0] {
    S_IDLE, S_TH_WAIT, S_PM, S_MX0, S_SCL, S_RMUL, S_RNUM, S_RDIV,
    S_NORM, S_PH_WAIT, S_PH_MUL, S_SQ, S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  out_word_t out_word_q;

  // Job fields
  logic        bad_q, neg_q, zero_q;
  logic [2:0]  l_q, am_q;
  logic [31:0] phi_turn_q;

  // Datapath
  logic signed [31:0]   x_q, s_q;
  logic signed [MW-1:0] q0_q, q1_q, a_q, y_q;
  logic [MW-1:0]        dq_q;
  logic                 dneg_q;
  logic [2:0]           rem_q, cnt_q;
  logic [DivCntW-1:0]   div_cnt_q;
  logic [3:0]           i_q;
  logic                 mph_q;
  logic [PartW-1:0]     part_q;

  cordic_req_t cor_req;
  cordic_rsp_t cor_rsp;

  logic                 l_gt_am, mul_state;
  logic signed [MW-1:0] mul_a, mul_res, num, sat_src;
  logic signed [31:0]   mul_b, sat_val, s_clamped;
  logic [MW-1:0]        mag_a, mag_r;
  logic [31:0]          mag_b;
  logic [HalfW-1:0]     half_a;
  logic [PartW-1:0]     part;
  logic [ProdW-1:0]     full;
  logic [4:0]           c_odd, c_lag;
  logic [2:0]           dsr, rem_d;
  logic [6:0]           dv;
  logic [3:0]           digit;
  logic [MW-1:0]        dq_d, num_mag;
  out_word_t            res_word;

  rshe_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  assign l_gt_am     = (l_q > am_q);
  assign mul_state   = state_q inside {S_PM, S_MX0, S_RMUL, S_NORM, S_PH_MUL, S_SQ};
  assign job_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // CORDIC launches: theta on job pop, phi after the norm product
  always_comb begin
    cor_req.start = ((state_q == S_IDLE) && job_valid_i && !job_word_i.bad) ||
                    ((state_q == S_NORM) && mph_q && !zero_q);
    cor_req.turn  = (state_q == S_IDLE) ? job_word_i.theta_turn : phi_turn_q;
  end

  // Shared multiplier: two passes, low half of |a| first, magnitude truncated by 30 bits
  always_comb begin
    case (state_q)
      S_PM: begin
        mul_a = -q0_q;
        mul_b = s_q;
      end
      S_MX0: begin
        mul_a = q0_q;
        mul_b = x_q;
      end
      S_RMUL: begin
        mul_a = q1_q;
        mul_b = x_q;
      end
      S_NORM: begin
        mul_a = l_gt_am ? q1_q : q0_q;
        mul_b = $signed(NormRom[{l_q, am_q}]);
      end
      S_PH_MUL: begin
        mul_a = y_q;
        mul_b = neg_q ? 32'(cor_rsp.sin_val) : 32'(cor_rsp.cos_val);
      end
      default: begin
        mul_a = y_q;
        mul_b = Sqrt2;
      end
    endcase
    mag_a   = mul_a[MW-1] ? MW'(-mul_a) : MW'(mul_a);
    mag_b   = mul_b[31] ? 32'(-mul_b) : 32'(mul_b);
    half_a  = mph_q ? mag_a[MW-1:HalfW] : mag_a[HalfW-1:0];
    part    = PartW'(half_a) * PartW'(mag_b);
    full    = {part, {HalfW{1'b0}}} + ProdW'(part_q);
    mag_r   = full[MW+29:30];
    mul_res = (mul_a[MW-1] ^ mul_b[31]) ? -mag_r : mag_r;
  end

  // Recurrence numerator and divider step (4 quotient bits a cycle)
  always_comb begin
    c_odd = {i_q, 1'b0} - 5'd1;
    c_lag = 5'(i_q) + 5'(am_q) - 5'd1;
    num = MW'(a_q * $signed({1'b0, c_odd})) - MW'(q0_q * $signed({1'b0, c_lag}));
    num_mag = num[MW-1] ? MW'(-num) : MW'(num);
    dsr = 3'(i_q - 4'(am_q));
    dv = {rem_q, dq_q[MW-1 -: 4]};
    digit = '0;
    for (int k = 1; k < 16; k++) begin
      if (7'(k) * {4'b0000, dsr} <= dv) digit = 4'(k);
    end
    rem_d = 3'(dv - {3'b000, digit} * {4'b0000, dsr});
    dq_d = {dq_q[MW-5:0], digit};
  end

  // Final scaling to Q3.28 with saturation
  always_comb begin
    sat_src = y_q >>> 2;
    if ((&sat_src[MW-1:31]) || !(|sat_src[MW-1:31])) begin
      sat_val = sat_src[31:0];
    end else begin
      sat_val = sat_src[MW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    res_word.harmonic_value = bad_q ? 32'sd0 : sat_val;
    res_word.bad_order      = bad_q;
    s_clamped = clamp_unit(cor_rsp.sin_val);
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mph_q       <= 1'b0;
    end else begin
      mph_q <= mul_state && !mph_q;
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) state_q <= job_word_i.bad ? S_FIN : S_TH_WAIT;
        end
        S_TH_WAIT: begin
          if (cor_rsp.done) begin
            if (am_q != 3'd0) state_q <= S_PM;
            else              state_q <= l_gt_am ? S_MX0 : S_NORM;
          end
        end
        S_PM: begin
          if (mph_q && (cnt_q == 3'd1)) state_q <= l_gt_am ? S_MX0 : S_NORM;
        end
        S_MX0:  if (mph_q) state_q <= S_SCL;
        S_SCL:  state_q <= (l_q == am_q + 3'd1) ? S_NORM : S_RMUL;
        S_RMUL: if (mph_q) state_q <= S_RNUM;
        S_RNUM: state_q <= S_RDIV;
        S_RDIV: begin
          if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
            state_q <= (i_q >= 4'(l_q)) ? S_NORM : S_RMUL;
          end
        end
        S_NORM:    if (mph_q) state_q <= zero_q ? S_FIN : S_PH_WAIT;
        S_PH_WAIT: if (cor_rsp.done) state_q <= S_PH_MUL;
        S_PH_MUL:  if (mph_q) state_q <= S_SQ;
        S_SQ:      if (mph_q) state_q <= S_FIN;
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_word_q  <= res_word;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (!mph_q) part_q <= part;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          bad_q      <= job_word_i.bad;
          l_q        <= job_word_i.band;
          am_q       <= job_word_i.abs_order;
          neg_q      <= job_word_i.order_neg;
          zero_q     <= job_word_i.order_zero;
          phi_turn_q <= job_word_i.phi_turn;
        end
      end
      S_TH_WAIT: begin
        if (cor_rsp.done) begin
          x_q   <= clamp_unit(cor_rsp.cos_val);
          s_q   <= s_clamped[31] ? 32'sd0 : s_clamped;
          q0_q  <= MW'(ONE_Q30);
          cnt_q <= am_q;
        end
      end
      S_PM: begin
        if (mph_q) begin
          q0_q  <= mul_res;
          cnt_q <= cnt_q - 3'd1;
        end
      end
      S_MX0: if (mph_q) a_q <= mul_res;
      S_SCL: begin
        q1_q <= MW'(a_q * $signed({1'b0, 4'({am_q, 1'b1})}));
        i_q  <= 4'(am_q) + 4'd2;
      end
      S_RMUL: if (mph_q) a_q <= mul_res;
      S_RNUM: begin
        q0_q      <= q1_q;
        dq_q      <= num_mag;
        dneg_q    <= num[MW-1];
        rem_q     <= '0;
        div_cnt_q <= '0;
      end
      S_RDIV: begin
        dq_q      <= dq_d;
        rem_q     <= rem_d;
        div_cnt_q <= div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          q1_q <= dneg_q ? -$signed(dq_d) : $signed(dq_d);
          i_q  <= i_q + 4'd1;
        end
      end
      S_NORM:   if (mph_q) y_q <= mul_res;
      S_PH_MUL: if (mph_q) y_q <= mul_res;
      S_SQ:     if (mph_q) y_q <= mul_res;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
